// ----- rtl/core/fpr_pkg.sv -----
// Package for the FIFO page replacement block: payload structs, event codes,
// chain token and frame write types, default sizes. No dependencies.
package fpr_pkg;

  localparam int MAX_FRAMES_DEF = 8;
  localparam int PAGE_BITS_DEF  = 16;

  localparam logic [3:0]  FRAMES_RST = 4'd3;
  localparam logic [15:0] CNT_MAX    = 16'hFFFF;

  typedef enum logic [1:0] {
    EV_HIT     = 2'd0,
    EV_FILL    = 2'd1,
    EV_REPLACE = 2'd2
  } event_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_BUSY = 1'b1
  } state_t;

  typedef struct packed {
    logic [15:0] page_number;
    logic        last_reference;
  } page_req_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [2:0]  frame_index;
    logic [15:0] evicted_page;
    logic [15:0] fault_total;
    logic [15:0] reference_total;
    logic        final_result;
  } page_res_t;

  // Flags of the lookup token walking down the cell chain
  typedef struct packed {
    logic vld;
    logic last;
    logic hit;
    logic free;
  } tok_ctl_t;

  // Frame update broadcast to all cells
  typedef struct packed {
    logic we;
    logic clr;
  } frm_wr_t;

endpackage

// ----- rtl/core/fpr_cell.sv -----
// One frame cell of the FIFO page replacement chain: holds a frame and
// passes the lookup token on to the next cell. Depends on fpr_pkg.
module fpr_cell #(
  parameter int IDX       = 0,
  parameter int IDX_W     = 3,
  parameter int CNT_W     = 4,
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic [CNT_W-1:0]     active_cnt,
  input  logic [IDX_W-1:0]     ptr_eff,
  input  fpr_pkg::frm_wr_t     wr,
  input  logic [IDX_W-1:0]     wr_idx,
  input  logic [PAGE_BITS-1:0] wr_page,
  input  fpr_pkg::tok_ctl_t    tk_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  logic [IDX_W-1:0]     hit_idx_i,
  input  logic [IDX_W-1:0]     free_idx_i,
  input  logic [PAGE_BITS-1:0] victim_i,
  output fpr_pkg::tok_ctl_t    tk_o,
  output logic [PAGE_BITS-1:0] page_o,
  output logic [IDX_W-1:0]     hit_idx_o,
  output logic [IDX_W-1:0]     free_idx_o,
  output logic [PAGE_BITS-1:0] victim_o
);
  import fpr_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

  logic [PAGE_BITS-1:0] frm_page_r;
  logic                 frm_valid_r;

  tok_ctl_t             tk_r, tk_nxt;
  logic [PAGE_BITS-1:0] page_r;
  logic [IDX_W-1:0]     hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0]     free_idx_r, free_idx_nxt;
  logic [PAGE_BITS-1:0] victim_r, victim_nxt;

  logic active;

  assign active = (active_cnt > MY_CNT);

  always_comb begin
    tk_nxt       = tk_i;
    hit_idx_nxt  = hit_idx_i;
    free_idx_nxt = free_idx_i;
    victim_nxt   = victim_i;
    if (active && frm_valid_r && (frm_page_r == page_i) && !tk_i.hit) begin
      tk_nxt.hit  = 1'b1;
      hit_idx_nxt = MY_IDX;
    end
    if (active && !frm_valid_r && !tk_i.free) begin
      tk_nxt.free  = 1'b1;
      free_idx_nxt = MY_IDX;
    end
    if (active && (ptr_eff == MY_IDX)) begin
      victim_nxt = frm_page_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tk_r <= '0;
    end else if (adv) begin
      tk_r <= tk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      page_r     <= page_i;
      hit_idx_r  <= hit_idx_nxt;
      free_idx_r <= free_idx_nxt;
      victim_r   <= victim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frm_valid_r <= 1'b0;
    end else if (wr.clr) begin
      frm_valid_r <= 1'b0;
    end else if (wr.we && (wr_idx == MY_IDX)) begin
      frm_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!wr.clr && wr.we && (wr_idx == MY_IDX)) begin
      frm_page_r <= wr_page;
    end
  end

  assign tk_o       = tk_r;
  assign page_o     = page_r;
  assign hit_idx_o  = hit_idx_r;
  assign free_idx_o = free_idx_r;
  assign victim_o   = victim_r;

endmodule

// ----- rtl/core/fifo_page_replacement.sv -----
// Top level of the FIFO page replacement block: cell chain plus commit logic.
// Depends on fpr_pkg and fpr_cell.
//
// Usage:
//   in_*  : one page reference per transaction (page_number, last_reference).
//   out_* : one result per reference (event, frame, victim, running totals).
//   cfg_* : writes frames_in_use (low 4 bits of cfg_data); a write also
//           empties all frames and clears pointer and counters.
// A reference walks the row of MAX_FRAMES cells, one cell per cycle; each
// cell compares against its frame, notes the first free frame and grabs the
// victim page at the oldest-entry pointer. The token then commits: the frame
// row, pointer and counters are updated and the result is registered.
// Only one reference is in the cell chain at a time; a new reference is
// taken while the previous result still waits in the output register.
// Reset: all frames empty, pointer and counters zero, frames_in_use = 3.
// Receiver stall: the token parks in the last cell until the output register
// frees up; in_ready stays low meanwhile. A reference with last_reference
// set returns the final totals and then restarts the run.
module fifo_page_replacement #(
  parameter int MAX_FRAMES = fpr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = fpr_pkg::PAGE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fpr_pkg::page_req_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fpr_pkg::page_res_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data
);
  import fpr_pkg::*;

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);

  // control state
  state_t         state_r, state_nxt;
  logic [3:0]     frames_r, frames_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [15:0]    fault_r, fault_nxt;
  logic [15:0]    ref_r, ref_nxt;
  logic           out_valid_r, out_valid_nxt;
  page_res_t      out_data_r, out_data_nxt;

  logic in_acc, cfg_acc, commit, adv;
  logic [CNT_W-1:0] n_act;
  logic [IDX_W-1:0] ptr_eff;
  logic [31:0]      ptr_inc;

  // frame write broadcast
  frm_wr_t              wr;
  logic [IDX_W-1:0]     wr_idx;
  logic [PAGE_BITS-1:0] wr_page;

  // chain taps; slot 0 feeds the first cell
  tok_ctl_t             tk   [MAX_FRAMES+1];
  logic [PAGE_BITS-1:0] pg   [MAX_FRAMES+1];
  logic [IDX_W-1:0]     hidx [MAX_FRAMES+1];
  logic [IDX_W-1:0]     fidx [MAX_FRAMES+1];
  logic [PAGE_BITS-1:0] vic  [MAX_FRAMES+1];
  logic [MAX_FRAMES-1:0] tok_vld_vec;

  tok_ctl_t             tail;
  logic [IDX_W-1:0]     where;
  logic [1:0]           ev;
  logic [PAGE_BITS-1:0] victim;

  assign in_acc  = in_valid && in_ready;
  assign cfg_acc = cfg_valid && cfg_ready;

  // Active frame count: zero acts as one, oversize clamps to the row length
  always_comb begin
    if (frames_r == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(frames_r) > 32'(MAX_FRAMES)) begin
      n_act = CNT_W'(MAX_FRAMES);
    end else begin
      n_act = CNT_W'(frames_r);
    end
  end

  // Stale pointer (beyond the active frames) wraps to frame 0
  assign ptr_eff = (32'(ptr_r) >= 32'(n_act)) ? '0 : ptr_r;
  assign ptr_inc = 32'(ptr_eff) + 32'd1;

  // Input side of the chain
  always_comb begin
    tk[0]      = '0;
    tk[0].vld  = in_acc;
    tk[0].last = in_data.last_reference;
    pg[0]      = PAGE_BITS'(in_data.page_number);
    hidx[0]    = '0;
    fidx[0]    = '0;
    vic[0]     = '0;
  end

  assign tail   = tk[MAX_FRAMES];
  assign commit = tail.vld && (!out_valid_r || out_ready);
  assign adv    = !tail.vld || commit;

  generate
    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
      fpr_cell #(
        .IDX       (g),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W),
        .PAGE_BITS (PAGE_BITS)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .active_cnt (n_act),
        .ptr_eff    (ptr_eff),
        .wr         (wr),
        .wr_idx     (wr_idx),
        .wr_page    (wr_page),
        .tk_i       (tk[g]),
        .page_i     (pg[g]),
        .hit_idx_i  (hidx[g]),
        .free_idx_i (fidx[g]),
        .victim_i   (vic[g]),
        .tk_o       (tk[g+1]),
        .page_o     (pg[g+1]),
        .hit_idx_o  (hidx[g+1]),
        .free_idx_o (fidx[g+1]),
        .victim_o   (vic[g+1])
      );
      assign tok_vld_vec[g] = tk[g+1].vld;
    end
  endgenerate

  // Resolve the finished lookup
  always_comb begin
    if (tail.hit) begin
      ev     = EV_HIT;
      where  = hidx[MAX_FRAMES];
      victim = '0;
    end else if (tail.free) begin
      ev     = EV_FILL;
      where  = fidx[MAX_FRAMES];
      victim = '0;
    end else begin
      ev     = EV_REPLACE;
      where  = ptr_eff;
      victim = vic[MAX_FRAMES];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_BUSY;
      end
      ST_BUSY: begin
        if (commit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = !cfg_valid;
        cfg_ready = 1'b1;
      end
      ST_BUSY: begin
        in_ready  = 1'b0;
        cfg_ready = 1'b0;
      end
      default: begin
        in_ready  = 1'b0;
        cfg_ready = 1'b0;
      end
    endcase
  end

  // Commit: frame update, pointer, counters, result register
  always_comb begin
    frames_nxt    = frames_r;
    ptr_nxt       = ptr_r;
    fault_nxt     = fault_r;
    ref_nxt       = ref_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr            = '0;
    wr_idx        = where;
    wr_page       = pg[MAX_FRAMES];

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    if (cfg_acc) begin
      frames_nxt = cfg_data;
      ptr_nxt    = '0;
      fault_nxt  = '0;
      ref_nxt    = '0;
      wr.clr     = 1'b1;
    end else if (commit) begin
      if (!tail.hit && (fault_r != CNT_MAX)) fault_nxt = fault_r + 16'd1;
      if (ref_r != CNT_MAX) ref_nxt = ref_r + 16'd1;
      if (!tail.hit && !tail.free) begin
        ptr_nxt = (ptr_inc >= 32'(n_act)) ? '0 : IDX_W'(ptr_inc);
      end
      wr.we = !tail.hit;

      out_valid_nxt                = 1'b1;
      out_data_nxt.event_res       = ev;
      out_data_nxt.frame_index     = 3'(where);
      out_data_nxt.evicted_page    = 16'(victim);
      out_data_nxt.fault_total     = fault_nxt;
      out_data_nxt.reference_total = ref_nxt;
      out_data_nxt.final_result    = tail.last;

      // end of reference string: start a fresh run
      if (tail.last) begin
        ptr_nxt   = '0;
        fault_nxt = '0;
        ref_nxt   = '0;
        wr.clr    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      frames_r    <= FRAMES_RST;
      ptr_r       <= '0;
      fault_r     <= '0;
      ref_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      frames_r    <= frames_nxt;
      ptr_r       <= ptr_nxt;
      fault_r     <= fault_nxt;
      ref_r       <= ref_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_walk_len: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##MAX_FRAMES tail.vld)
    else $error("lookup token did not reach chain end on time");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_vld_vec) <= 1)
    else $error("more than one lookup token in the chain");

  a_fault_le_ref: assert property (@(posedge clk) disable iff (!rst_n)
    fault_r <= ref_r)
    else $error("fault count exceeds reference count");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && tail.last) |=> (ref_r == '0 && fault_r == '0 && ptr_r == '0))
    else $error("run state not cleared after final reference");

  a_busy_no_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BUSY) |-> (!in_ready && !cfg_ready))
    else $error("new transaction taken during a lookup");

endmodule
